// ===== sv/tsd_pkg.sv =====
// Shared widths, constants and bus types for the Taylor sine core.
// Used by every module of the block and by its checker; depends on nothing.
package tsd_pkg;

  // Number of series terms summed (x, x^3/3!, x^5/5!, ...). Range 4..16.
  localparam int TERMS = 10;

  // Port widths.
  localparam int ANGLE_W = 16;
  localparam int SINE_W  = 18;

  // Angle magnitude after clamping to 360 degrees in 1/64 degree.
  localparam int MAG_W = 15;
  localparam logic [MAG_W-1:0] ANGLE_LIMIT = 15'd23040;

  // Degrees to radians: x = round(mag * 3142 * 2^13 / 5625) in Q.24.
  localparam int P_W      = 27;
  localparam logic [11:0] PI_MILLI = 12'd3142;
  localparam int CONV_SH  = 40;
  localparam int CM_W     = 28;
  localparam logic [CM_W-1:0] CONV_M =
    CM_W'(((64'd1 << CONV_SH) + 64'd5624) / 64'd5625);
  localparam int CD_W     = 13;
  localparam logic [CD_W-1:0] CONV_D = 13'd5625;
  localparam logic [CD_W-1:0] CONV_HALF = 13'd2812;
  localparam int Q1_W     = 14;
  localparam int R1_W     = 13;
  localparam int LO_W     = 13;
  localparam int V1_W     = R1_W + LO_W;
  localparam int PR1_W    = P_W + CM_W;
  localparam int PR2_W    = V1_W + CM_W;

  // Radian angle and its square, Q.24.
  localparam int FRAC   = 24;
  localparam int X_W    = Q1_W + LO_W;
  localparam int XL_W   = 14;
  localparam int XH_W   = X_W - XL_W;
  localparam int SQ_W   = 2 * X_W;
  localparam int X2_W   = 30;

  // Term recurrence inside one cell.
  localparam int T_W    = 31;
  localparam int TH_W   = T_W - 16;
  localparam int TL_W   = 16;
  localparam int TX_W   = T_W + X2_W;
  localparam int U_W    = 36;
  localparam int UL_W   = 18;
  localparam int UH_W   = U_W - UL_W;
  localparam int V_W    = 28;
  localparam int R_W    = V_W - UL_W;
  localparam int M_W    = 29;
  localparam int QHP_W  = UH_W + M_W;
  localparam int QLP_W  = V_W + M_W;
  localparam int F_W    = 10;
  localparam int H_W    = 9;
  localparam int SH_W   = 6;

  // Signed running sum, Q.24.
  localparam int SUM_W  = 34;

  // Result rounding and saturation.
  localparam int Q16_W  = SUM_W - 8;
  localparam int ONE_W  = 17;
  localparam logic [ONE_W-1:0] ONE_Q16 = 17'd65536;

  // Pipeline depths and end-to-end latency in cycles.
  localparam int FRONT_ST = 8;
  localparam int CELL_ST  = 6;
  localparam int FIN_ST   = 2;
  localparam int LATENCY  = FRONT_ST + CELL_ST * (TERMS - 1) + FIN_ST;

  // One word moving down the row of cells.
  typedef struct packed {
    logic                    vld;
    logic                    neg;
    logic [X2_W-1:0]         x2;
    logic signed [SUM_W-1:0] sum;
    logic [T_W-1:0]          t;
  } term_bus_t;

  // Per-cell constants: divisor f = (2i)(2i+1), half of it, reciprocal, shift and odd-term flag.
  typedef struct packed {
    logic [F_W-1:0]  f;
    logic [H_W-1:0]  half;
    logic [M_W-1:0]  m;
    logic [SH_W-1:0] sh;
    logic            odd;
  } cell_cfg_t;

  function automatic int cell_f(input int idx);
    cell_f = (2 * idx) * (2 * idx + 1);
  endfunction

endpackage

// ===== sv/taylor_sine_degrees_core.sv =====
// Top level of the Taylor sine core: front end, row of term cells, rounding.
// Depends on tsd_pkg, tsd_front and tsd_cell.
//
//  channel | ports                      | width      | handshake
//  --------+----------------------------+------------+-------------------------------
//  input   | start, busy, in_angle_deg  | 16 signed  | taken when start & !busy
//  result  | out_valid, out_sine        | 18 signed  | one-cycle strobe, no back-pressure
//
// Flow: one word accepted every cycle while busy is low; each word passes the
//   front end, the TERMS-1 term cells and the rounding registers in turn. The
//   widest step of each cell, a 28 by 29 bit reciprocal multiply, sets the clock.
// Reset: synchronous, active low; drops every word in flight and holds busy
//   high until the cycle after release.
// Stalls: none; the receiver takes each result in the cycle it is strobed.
module taylor_sine_degrees_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tsd_pkg::ANGLE_W-1:0] in_angle_deg,
  output logic                               out_valid,
  output logic signed [tsd_pkg::SINE_W-1:0]  out_sine
);
  import tsd_pkg::*;

  logic busy_r;
  logic in_vld;

  // Bus between neighbors: entry 0 from the front end, entry i out of cell i.
  term_bus_t bus [TERMS];

  // Rounding stage registers.
  logic [FIN_ST-1:0]       fvld_r;
  logic                    rneg_r;
  logic [SUM_W-1:0]        amag_nxt, amag_r;
  logic [Q16_W-1:0]        q16_nxt;
  logic [ONE_W-1:0]        qsat_nxt;
  logic [SINE_W-1:0]       sine_nxt, sine_r;

  // Hold off start only while in reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign in_vld = start & ~busy_r;

  // Clamp, convert to radians and square.
  tsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_angle (in_angle_deg),
    .out_bus  (bus[0])
  );

  // Row of term cells; cell i divides by (2i)(2i+1) through a fixed
  // reciprocal, exact for every numerator below 2^V_W.
  for (genvar gi = 1; gi < TERMS; gi++) begin : g_cell
    localparam int F    = cell_f(gi);
    localparam int L    = $clog2(F);
    localparam int HALF = F / 2;
    localparam longint unsigned M = ((64'd1 << (V_W + L)) + 64'(F) - 64'd1) / 64'(F);
    localparam bit ODD  = (gi % 2) == 1;

    cell_cfg_t cfg_c;

    assign cfg_c.f    = F_W'(F);
    assign cfg_c.half = H_W'(HALF);
    assign cfg_c.m    = M_W'(M);
    assign cfg_c.sh   = SH_W'(V_W + L);
    assign cfg_c.odd  = ODD;

    tsd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg     (cfg_c),
      .in_bus  (bus[gi-1]),
      .out_bus (bus[gi])
    );
  end

  // Round |sum| to Q1.16 (half up), saturate at 1.0, restore the sign.
  always_comb begin
    amag_nxt = bus[TERMS-1].sum[SUM_W-1] ? SUM_W'(-bus[TERMS-1].sum)
                                          : SUM_W'(bus[TERMS-1].sum);
    q16_nxt  = Q16_W'((amag_r + SUM_W'(128)) >> 8);
    if (q16_nxt > Q16_W'(ONE_Q16)) begin
      qsat_nxt = ONE_Q16;
    end else begin
      qsat_nxt = q16_nxt[ONE_W-1:0];
    end
    sine_nxt = rneg_r ? (SINE_W'(0) - SINE_W'(qsat_nxt)) : SINE_W'(qsat_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r <= '0;
    end else begin
      fvld_r <= {fvld_r[FIN_ST-2:0], bus[TERMS-1].vld};
    end
  end

  always_ff @(posedge clk) begin
    rneg_r <= bus[TERMS-1].sum[SUM_W-1];
    amag_r <= amag_nxt;
    sine_r <= sine_nxt;
  end

  assign out_valid = fvld_r[FIN_ST-1];
  assign out_sine  = $signed(sine_r);

endmodule

// ===== sv/tsd_front.sv =====
// Front end: clamp the angle, convert degrees to radians and square the result.
// Depends on tsd_pkg; feeds the first term cell.
module tsd_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic signed [tsd_pkg::ANGLE_W-1:0] in_angle,
  output tsd_pkg::term_bus_t                 out_bus
);
  import tsd_pkg::*;

  logic [FRONT_ST-1:0] vld_r;
  logic [FRONT_ST-1:0] neg_r;

  logic [ANGLE_W-1:0]  abs_nxt;
  logic [MAG_W-1:0]    mag_nxt, mag_r;
  logic [P_W-1:0]      p_r, p2_r;
  logic [PR1_W-1:0]    pr1_r;
  logic [Q1_W-1:0]     q1_nxt, q1a_r, q1b_r;
  logic [R1_W-1:0]     r1_nxt, r1_r;
  logic [V1_W-1:0]     v1_nxt;
  logic [PR2_W-1:0]    pr2_r;
  logic [X_W-1:0]      x_nxt, x_r, x7_r;
  logic [XH_W-1:0]     xh;
  logic [XL_W-1:0]     xl;
  logic [2*XH_W-1:0]   hh_r;
  logic [XH_W+XL_W-1:0] hl_r;
  logic [2*XL_W-1:0]   ll_r;
  logic [SQ_W-1:0]     sq_nxt;
  logic signed [SUM_W-1:0] xs_ext, sum_nxt, sum_r;
  logic [X2_W-1:0]     x2_r;
  logic [T_W-1:0]      t_r;

  always_comb begin
    abs_nxt = in_angle[ANGLE_W-1] ? (~in_angle + 1'b1) : in_angle;
    if (abs_nxt > ANGLE_W'(ANGLE_LIMIT)) begin
      mag_nxt = ANGLE_LIMIT;
    end else begin
      mag_nxt = abs_nxt[MAG_W-1:0];
    end
  end

  always_comb begin
    q1_nxt = pr1_r[CONV_SH+Q1_W-1:CONV_SH];
    r1_nxt = R1_W'(p2_r - P_W'(q1_nxt) * P_W'(CONV_D));
    v1_nxt = {r1_r, {LO_W{1'b0}}} + V1_W'(CONV_HALF);
    x_nxt  = {q1b_r, pr2_r[CONV_SH+LO_W-1:CONV_SH]};
    xh     = x_r[X_W-1:XL_W];
    xl     = x_r[XL_W-1:0];
    sq_nxt = (SQ_W'(hh_r) << (2 * XL_W)) + (SQ_W'(hl_r) << (XL_W + 1)) + SQ_W'(ll_r)
             + (SQ_W'(1) << (FRAC - 1));
    xs_ext = $signed({{(SUM_W-X_W){1'b0}}, x7_r});
    sum_nxt = neg_r[FRONT_ST-2] ? -xs_ext : xs_ext;
  end

  // Control: advance valid and sign flags every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_ST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= {neg_r[FRONT_ST-2:0], in_angle[ANGLE_W-1]};
    mag_r <= mag_nxt;
    p_r   <= P_W'(mag_r) * P_W'(PI_MILLI);
    pr1_r <= PR1_W'(p_r) * PR1_W'(CONV_M);
    p2_r  <= p_r;
    q1a_r <= q1_nxt;
    r1_r  <= r1_nxt;
    q1b_r <= q1a_r;
    pr2_r <= PR2_W'(v1_nxt) * PR2_W'(CONV_M);
    x_r   <= x_nxt;
    hh_r  <= (2*XH_W)'(xh) * (2*XH_W)'(xh);
    hl_r  <= (XH_W+XL_W)'(xh) * (XH_W+XL_W)'(xl);
    ll_r  <= (2*XL_W)'(xl) * (2*XL_W)'(xl);
    x7_r  <= x_r;
    x2_r  <= sq_nxt[FRAC+X2_W-1:FRAC];
    t_r   <= T_W'(x7_r);
    sum_r <= sum_nxt;
  end

  assign out_bus.vld = vld_r[FRONT_ST-1];
  assign out_bus.neg = neg_r[FRONT_ST-1];
  assign out_bus.x2  = x2_r;
  assign out_bus.sum = sum_r;
  assign out_bus.t   = t_r;

endmodule

// ===== sv/tsd_cell.sv =====
// One term cell: next term = round(t * x^2 / f), then add or subtract it.
// Depends on tsd_pkg; chained by the top level, constants come in on cfg.
module tsd_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tsd_pkg::cell_cfg_t cfg,
  input  tsd_pkg::term_bus_t in_bus,
  output tsd_pkg::term_bus_t out_bus
);
  import tsd_pkg::*;

  logic [CELL_ST-1:0]      vld_r;
  logic [CELL_ST-1:0]      neg_r;
  logic [X2_W-1:0]         x2_r  [CELL_ST];
  logic signed [SUM_W-1:0] sum_r [CELL_ST-1];

  logic [TH_W+X2_W-1:0]    phi_r;
  logic [TL_W+X2_W-1:0]    plo_r;
  logic [TX_W-1:0]         txp_nxt;
  logic [U_W-1:0]          u_nxt, u_r;
  logic [QHP_W-1:0]        qhp_r;
  logic [UH_W-1:0]         uh_r, qh_nxt, qh_r, qh2_r, qf_nxt;
  logic [UL_W-1:0]         ul_r, ql_nxt;
  logic [R_W-1:0]          rh_nxt;
  logic [V_W-1:0]          v_r;
  logic [QLP_W-1:0]        qlp_r;
  logic [T_W-1:0]          t_nxt, t_r;
  logic                    tneg;
  logic signed [SUM_W-1:0] t_ext, sum_nxt, sum_out_r;

  always_comb begin
    txp_nxt = (TX_W'(phi_r) << TL_W) + TX_W'(plo_r);
    u_nxt   = U_W'(txp_nxt >> FRAC) + U_W'(cfg.half);
    qh_nxt  = UH_W'(qhp_r >> cfg.sh);
    qf_nxt  = UH_W'(qh_nxt) * UH_W'(cfg.f);
    rh_nxt  = R_W'(uh_r - qf_nxt);
    ql_nxt  = UL_W'(qlp_r >> cfg.sh);
    t_nxt   = T_W'({qh2_r, ql_nxt});
    tneg    = neg_r[CELL_ST-2] ^ cfg.odd;
    t_ext   = $signed({{(SUM_W-T_W){1'b0}}, t_nxt});
    sum_nxt = tneg ? (sum_r[CELL_ST-2] - t_ext) : (sum_r[CELL_ST-2] + t_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CELL_ST-2:0], in_bus.vld};
    end
  end

  // Side band: hold x^2, sign and running sum alongside the term.
  always_ff @(posedge clk) begin
    neg_r    <= {neg_r[CELL_ST-2:0], in_bus.neg};
    x2_r[0]  <= in_bus.x2;
    sum_r[0] <= in_bus.sum;
    for (int k = 1; k < CELL_ST; k++) begin
      x2_r[k] <= x2_r[k-1];
    end
    for (int k = 1; k < CELL_ST - 1; k++) begin
      sum_r[k] <= sum_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    phi_r     <= (TH_W+X2_W)'(in_bus.t[T_W-1:TL_W]) * (TH_W+X2_W)'(in_bus.x2);
    plo_r     <= (TL_W+X2_W)'(in_bus.t[TL_W-1:0]) * (TL_W+X2_W)'(in_bus.x2);
    u_r       <= u_nxt;
    qhp_r     <= QHP_W'(u_r[U_W-1:UL_W]) * QHP_W'(cfg.m);
    uh_r      <= u_r[U_W-1:UL_W];
    ul_r      <= u_r[UL_W-1:0];
    qh_r      <= qh_nxt;
    v_r       <= {rh_nxt, ul_r};
    qlp_r     <= QLP_W'(v_r) * QLP_W'(cfg.m);
    qh2_r     <= qh_r;
    t_r       <= t_nxt;
    sum_out_r <= sum_nxt;
  end

  assign out_bus.vld = vld_r[CELL_ST-1];
  assign out_bus.neg = neg_r[CELL_ST-1];
  assign out_bus.x2  = x2_r[CELL_ST-1];
  assign out_bus.sum = sum_out_r;
  assign out_bus.t   = t_r;

endmodule

// ===== sv/tsd_checker.sv =====
// Port-level checks on the Taylor sine core: latency, range, reset behavior.
// Depends on tsd_pkg; bound to taylor_sine_degrees_core below.
module tsd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic signed [tsd_pkg::ANGLE_W-1:0] in_angle_deg,
  input logic                               out_valid,
  input logic signed [tsd_pkg::SINE_W-1:0]  out_sine
);
  import tsd_pkg::*;

  // Every accepted word yields a result at the end of the pipeline.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after accepted word");

  // No result without a matching word accepted at the pipeline input.
  a_no_orphan : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching input word");

  // Output stays within plus or minus 1.0.
  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_sine) <= 65536 && $signed(out_sine) >= -65536))
    else $error("sine out of range");

  // Zero angle gives zero sine.
  a_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_angle_deg, LATENCY) == 0) |-> out_sine == 0)
    else $error("nonzero sine for zero angle");

  // Busy is low whenever reset was also released in the previous cycle.
  a_busy : assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> !busy)
    else $error("busy high outside reset");

endmodule

bind taylor_sine_degrees_core tsd_checker u_tsd_checker (.*);

// ===== dv/taylor_sine_degrees_checker.sv =====
// Checker for the Taylor sine core: watches the angle and sine channels,
// predicts each sine from the accepted angle and compares in order.
// Depends on tsd_pkg for widths, the term count and the angle limit.
`timescale 1ns / 1ps

module taylor_sine_degrees_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [tsd_pkg::ANGLE_W-1:0] in_angle_deg,
  input  logic                               out_valid,
  input  logic signed [tsd_pkg::SINE_W-1:0]  out_sine,
  output int                                 fail_count,
  output int                                 sines_due,
  output int                                 sines_checked,
  output int                                 sines_saturated
);

  localparam longint unsigned DEG64_TO_RAD_DEN = 64'd180000;
  localparam longint unsigned FULL_SCALE_Q16   = 64'd65536;

  typedef struct {
    logic signed [tsd_pkg::ANGLE_W-1:0] angle;
    logic signed [tsd_pkg::SINE_W-1:0]  sine;
  } sine_due_t;

  sine_due_t sine_due_q[$];

  // Series sine of an angle in 1/64 degree, Q1.16 result, saturated.
  function automatic logic signed [tsd_pkg::SINE_W-1:0] series_sine(
    input logic signed [tsd_pkg::ANGLE_W-1:0] angle
  );
    logic            neg;
    logic            sum_neg;
    longint unsigned mag;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned f;
    longint unsigned amag;
    longint unsigned q16;
    longint          acc;
    neg = angle[tsd_pkg::ANGLE_W-1];
    mag = neg ? 64'd65536 - 64'(angle[15:0]) : 64'(angle[15:0]);
    if (mag > 64'(tsd_pkg::ANGLE_LIMIT))
      mag = 64'(tsd_pkg::ANGLE_LIMIT);
    // degrees*64 to radians in Q.24, rounded half up
    x = (mag * 64'(tsd_pkg::PI_MILLI) * (64'd1 << 18) + DEG64_TO_RAD_DEN / 2)
        / DEG64_TO_RAD_DEN;
    x2 = (x * x + (64'd1 << 23)) >> 24;
    t = x;
    acc = neg ? -longint'(t) : longint'(t);
    for (int i = 1; i < tsd_pkg::TERMS; i++) begin
      f = 64'((2 * i) * (2 * i + 1));
      t = (t * x2 + f * (64'd1 << 23)) / (f << 24);
      if (neg ^ i[0])
        acc -= longint'(t);
      else
        acc += longint'(t);
    end
    sum_neg = acc < 0;
    amag = sum_neg ? longint'(-acc) : longint'(acc);
    q16 = (amag + 64'd128) >> 8;
    if (q16 > FULL_SCALE_Q16)
      q16 = FULL_SCALE_Q16;
    series_sine = sum_neg ? tsd_pkg::SINE_W'(-q16) : tsd_pkg::SINE_W'(q16);
  endfunction

  initial begin
    fail_count      = 0;
    sines_checked   = 0;
    sines_saturated = 0;
  end

  assign sines_due = sine_due_q.size();

  always @(posedge clk) begin
    sine_due_t due;
    if (rst_n) begin
      if (out_valid) begin
        if (sine_due_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected sine word %0d, nothing outstanding", $time, out_sine);
        end else begin
          due = sine_due_q.pop_front();
          sines_checked++;
          if (due.sine == 18'sd65536 || due.sine == -18'sd65536)
            sines_saturated++;
          if (out_sine !== due.sine) begin
            fail_count++;
            $display("%0t: sine mismatch for angle %0d: expected %0d, actual %0d",
                     $time, due.angle, due.sine, out_sine);
          end
        end
      end
      if (start && !busy) begin
        due.angle = in_angle_deg;
        due.sine  = series_sine(in_angle_deg);
        sine_due_q.push_back(due);
      end
    end
  end

endmodule

// ===== dv/taylor_sine_degrees_core_tb.sv =====
// Testbench top for the Taylor sine core: clock, reset, angle stimulus, verdict.
// Depends on tsd_pkg, taylor_sine_degrees_core and taylor_sine_degrees_checker.
`timescale 1ns / 1ps

module taylor_sine_degrees_core_tb;

  // 1/64 degree units for the angles that matter most
  localparam int DEG_90    = 5760;
  localparam int DEG_360   = 23040;
  localparam int RANDOM_N  = 1600;
  localparam int CYCLE_CAP = 600000;
  localparam int DRAIN_CYC = tsd_pkg::LATENCY + 16;

  logic                               clk          = 1'b0;
  logic                               rst_n        = 1'b0;
  logic                               start        = 1'b0;
  logic signed [tsd_pkg::ANGLE_W-1:0] in_angle_deg = '0;
  logic                               busy;
  logic                               out_valid;
  logic signed [tsd_pkg::SINE_W-1:0]  out_sine;

  int fail_count;
  int sines_due;
  int sines_checked;
  int sines_saturated;
  int cycle_count = 0;
  int angles_sent = 0;
  int angles_clamped = 0;
  int burst_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  taylor_sine_degrees_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_angle_deg (in_angle_deg),
    .out_valid    (out_valid),
    .out_sine     (out_sine)
  );

  taylor_sine_degrees_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_angle_deg    (in_angle_deg),
    .out_valid       (out_valid),
    .out_sine        (out_sine),
    .fail_count      (fail_count),
    .sines_due       (sines_due),
    .sines_checked   (sines_checked),
    .sines_saturated (sines_saturated)
  );

  // Watchdog: a hung handshake or a lost sine word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d sine words outstanding",
               cycle_count, sines_due);
      $display("taylor_sine_degrees_core regression: fail");
      $finish;
    end
  end

  // Present one angle word and hold it until the core takes it. The busy
  // read right after the edge is the value the core saw at that edge.
  task automatic drive_angle(input logic signed [tsd_pkg::ANGLE_W-1:0] angle);
    start        <= 1'b1;
    in_angle_deg <= angle;
    do
      @(posedge clk);
    while (busy);
    angles_sent++;
    if (angle > DEG_360 || angle < -DEG_360)
      angles_clamped++;
  endtask

  // Idle the input side for a random while. Stretches with no gap at all
  // keep the pipeline full; most gaps are short, a few span many cycles.
  // Keep start high into the next word when there is no gap, so it is never
  // dropped and raised in the same step.
  task automatic idle_between_words();
    int roll;
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    roll = $urandom_range(99);
    if (roll < 8) begin
      burst_left = $urandom_range(60, 10);
      gap = 0;
    end else if (roll < 50) begin
      gap = 0;
    end else if (roll < 94) begin
      gap = $urandom_range(3, 1);
    end else begin
      gap = $urandom_range(90, 15);
    end
    if (gap > 0) begin
      start <= 1'b0;
      // scribble on the angle while idle; the core must ignore it
      in_angle_deg <= tsd_pkg::ANGLE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random angle: mostly in range, some near quadrant edges, some tiny,
  // some anywhere in the 16-bit field so the clamp and every bit get hit.
  function automatic logic signed [tsd_pkg::ANGLE_W-1:0] pick_angle();
    int roll;
    int quadrant;
    roll = $urandom_range(99);
    if (roll < 65) begin
      pick_angle = tsd_pkg::ANGLE_W'(int'($urandom_range(2 * DEG_360)) - DEG_360);
    end else if (roll < 78) begin
      quadrant = int'($urandom_range(8)) - 4;
      pick_angle = tsd_pkg::ANGLE_W'(quadrant * DEG_90 + int'($urandom_range(16)) - 8);
    end else if (roll < 88) begin
      pick_angle = tsd_pkg::ANGLE_W'(int'($urandom_range(128)) - 64);
    end else begin
      pick_angle = tsd_pkg::ANGLE_W'($urandom);
    end
  endfunction

  initial begin
    int directed_angles[$];
    directed_angles = '{
      0, 1, -1, 64, -64,
      DEG_90 / 3, DEG_90, -DEG_90, DEG_90 - 1, DEG_90 + 1,
      2 * DEG_90, -2 * DEG_90, 3 * DEG_90, -3 * DEG_90,
      DEG_360 - 1, -(DEG_360 - 1), DEG_360, -DEG_360,
      DEG_360 + 1, -(DEG_360 + 1),
      32767, -32768, 16384, -16385, 21000
    };

    // Hold reset from time zero, then release once and for all.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, tiny angles, quadrant points, the range edges and
    // angles past the clamp, back to back.
    foreach (directed_angles[k])
      drive_angle(tsd_pkg::ANGLE_W'(directed_angles[k]));

    // Random words with random gaps on the input side.
    for (int n = 0; n < RANDOM_N; n++) begin
      idle_between_words();
      drive_angle(pick_angle());
    end
    start <= 1'b0;
    @(posedge clk);

    // Drain: wait for every predicted sine word, then watch for strays.
    wait (sines_due == 0);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("sent %0d angle words (%0d past +/-360 deg), checked %0d sine words",
             angles_sent, angles_clamped, sines_checked);
    $display("%0d sine words at full scale, %0d failures", sines_saturated, fail_count);
    if (fail_count == 0)
      $display("taylor_sine_degrees_core regression: pass");
    else
      $display("taylor_sine_degrees_core regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tsd_pkg.sv
sv/tsd_front.sv
sv/tsd_cell.sv
sv/taylor_sine_degrees_core.sv
sv/tsd_checker.sv
dv/taylor_sine_degrees_checker.sv
dv/taylor_sine_degrees_core_tb.sv
